/* rtl/core/v3a_pkg.sv */
package v3a_pkg;

    localparam logic [3:0] OP_ADD       = 4'd0;
    localparam logic [3:0] OP_SUB       = 4'd1;
    localparam logic [3:0] OP_MUL       = 4'd2;
    localparam logic [3:0] OP_SCALE     = 4'd3;
    localparam logic [3:0] OP_NEGATE    = 4'd4;
    localparam logic [3:0] OP_ABS       = 4'd5;
    localparam logic [3:0] OP_CROSS     = 4'd6;
    localparam logic [3:0] OP_DOT       = 4'd7;
    localparam logic [3:0] OP_LERP      = 4'd8;
    localparam logic [3:0] OP_LENGTH    = 4'd9;
    localparam logic [3:0] OP_NORMALIZE = 4'd10;
    localparam logic [3:0] OP_REFLECT   = 4'd11;

    localparam logic signed [65:0] Q_MAX = 66'sd2147483647;
    localparam logic signed [65:0] Q_MIN = -66'sd2147483648;

    // one queued item, slow marks the iterative actions
    typedef struct packed {
        logic [3:0]       op;
        logic             slow;
        logic [31:0]      sc;
        logic [2:0][31:0] b;
        logic [2:0][31:0] a;
    } item_t;

    typedef struct packed {
        logic             sat;
        logic [31:0]      so;
        logic [2:0][31:0] r;
    } res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } slow_stat_t;

    typedef struct packed {
        logic        f;
        logic [31:0] v;
    } sat_t;

    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t o;
        if (v > Q_MAX)
        begin
            o.f = 1'b1;
            o.v = 32'h7FFF_FFFF;
        end
        else if (v < Q_MIN)
        begin
            o.f = 1'b1;
            o.v = 32'h8000_0000;
        end
        else
        begin
            o.f = 1'b0;
            o.v = v[31:0];
        end
        return o;
    endfunction

    // divide by 2^16 truncating toward zero
    function automatic logic signed [65:0] trunc16(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v[65] ? v + 66'sd65535 : v;
        return t >>> 16;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

endpackage

/* rtl/core/v3a_front.sv */
module v3a_front
    import v3a_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,
    input  logic [3:0]   s_tuser,
    output item_t        push_item,
    output logic         push_valid,
    input  logic         push_ready
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        item_next.op = s_tuser;
        item_next.a  = s_tdata[95:0];
        item_next.b  = s_tdata[191:96];
        item_next.sc = s_tdata[223:192];
        item_next.slow = (s_tuser == OP_LENGTH) || (s_tuser == OP_NORMALIZE) ||
                         (s_tuser == OP_REFLECT);
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
            valid_next = 1'b1;
        else if (push_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= item_next;
    end

endmodule

/* rtl/core/v3a_fifo.sv */
module v3a_fifo
    import v3a_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t push_item,
    input  logic  push_valid,
    output logic  push_ready,
    output item_t head_item,
    output logic  head_valid,
    input  logic  pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

/* rtl/core/v3a_slow.sv */
module v3a_slow
    import v3a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  item_t      item,
    input  logic       take,
    output slow_stat_t stat,
    output res_t       res
);

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_SQ_MUL  = 13'b0000000000010,
        ST_SQ_ACC  = 13'b0000000000100,
        ST_SQRT    = 13'b0000000001000,
        ST_DINIT   = 13'b0000000010000,
        ST_DIV     = 13'b0000000100000,
        ST_DOT_MUL = 13'b0000001000000,
        ST_DOT_ACC = 13'b0000010000000,
        ST_DBL     = 13'b0000100000000,
        ST_W_MUL   = 13'b0001000000000,
        ST_W_ACC   = 13'b0010000000000,
        ST_SC_MUL  = 13'b0100000000000,
        ST_SC_ACC  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    logic [3:0]         op_reg, op_next;
    logic               pass_reg, pass_next;
    logic [1:0]         idx_reg, idx_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [2:0][31:0]   vec_reg, vec_next;
    logic [2:0][31:0]   b_reg, b_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [65:0] prod_reg, prod_next;
    logic [63:0]        x_reg, x_next;
    logic [63:0]        root_reg, root_next;
    logic [63:0]        bit_reg, bit_next;
    logic [31:0]        len_reg, len_next;
    logic [31:0]        la_reg, la_next;
    logic [31:0]        d_reg, d_next;
    logic [47:0]        rem_reg, rem_next;
    logic [47:0]        dsh_reg, dsh_next;
    logic [16:0]        quo_reg, quo_next;
    logic [2:0][17:0]   q_reg, q_next;
    res_t               res_reg, res_next;

    logic signed [32:0] mul_x;
    logic signed [32:0] mul_y;
    logic signed [65:0] acc_sum;
    logic [63:0]        rb_sum;
    logic [16:0]        quo_fin;
    logic signed [17:0] q_fin;
    sat_t               s1;
    sat_t               s2;

    assign stat.busy = (state_reg != ST_IDLE) || done_reg;
    assign stat.done = done_reg;
    assign res       = res_reg;
    assign acc_sum   = acc_reg + prod_reg;
    assign rb_sum    = root_reg + bit_reg;
    assign prod_next = 66'(mul_x) * 66'(mul_y);

    // shared multiplier operand select
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (state_reg)
            ST_SQ_MUL:
            begin
                mul_x = $signed({1'b0, mag32(vec_reg[idx_reg])});
                mul_y = $signed({1'b0, mag32(vec_reg[idx_reg])});
            end
            ST_DOT_MUL:
            begin
                mul_x = -33'($signed(q_reg[idx_reg]));
                mul_y = 33'($signed(b_reg[idx_reg]));
            end
            ST_W_MUL:
            begin
                mul_x = 33'($signed(b_reg[idx_reg]));
                mul_y = 33'($signed(d_reg));
            end
            ST_SC_MUL:
            begin
                mul_x = 33'($signed(q_reg[idx_reg]));
                mul_y = $signed({1'b0, la_reg});
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        op_next    = op_reg;
        pass_next  = pass_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        vec_next   = vec_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        len_next   = len_reg;
        la_next    = la_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        quo_fin    = (rem_reg >= dsh_reg) ? {quo_reg[15:0], 1'b1} : {quo_reg[15:0], 1'b0};
        q_fin      = (len_reg == '0) ? '0 :
                     (vec_reg[idx_reg][31] ? -$signed({1'b0, quo_fin}) :
                      $signed({1'b0, quo_fin}));
        s1         = '0;
        s2         = '0;

        if (done_reg && take)
            done_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = item.op;
                    vec_next   = item.a;
                    b_next     = item.b;
                    pass_next  = 1'b0;
                    idx_next   = '0;
                    acc_next   = '0;
                    res_next   = '0;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL:
                state_next = ST_SQ_ACC;
            ST_SQ_ACC:
            begin
                acc_next = acc_sum;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    x_next     = acc_sum[63:0];
                    root_next  = '0;
                    bit_next   = 64'd1 << 62;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQRT:
            begin
                if (x_reg >= rb_sum)
                begin
                    x_next    = x_reg - rb_sum;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                    root_next = root_reg >> 1;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    len_next = root_next[31:0];
                    if (op_reg == OP_LENGTH)
                    begin
                        s1 = sat32($signed({34'd0, root_next[31:0]}));
                        res_next.so  = s1.v;
                        res_next.sat = s1.f;
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                        state_next = ST_DINIT;
                end
            end
            ST_DINIT:
            begin
                rem_next   = {mag32(vec_reg[idx_reg]), 16'd0};
                dsh_next   = {len_reg, 16'd0};
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                    rem_next = rem_reg - dsh_reg;
                quo_next = quo_fin;
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd16)
                begin
                    q_next[idx_reg] = q_fin;
                    if (idx_reg != 2'd2)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_DINIT;
                    end
                    else
                    begin
                        idx_next = '0;
                        if (pass_reg)
                            state_next = ST_SC_MUL;
                        else if (op_reg == OP_NORMALIZE)
                        begin
                            res_next.r[0] = 32'($signed(q_next[0]));
                            res_next.r[1] = 32'($signed(q_next[1]));
                            res_next.r[2] = 32'($signed(q_next[2]));
                            done_next     = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            la_next    = len_reg;
                            acc_next   = '0;
                            state_next = ST_DOT_MUL;
                        end
                    end
                end
            end
            ST_DOT_MUL:
                state_next = ST_DOT_ACC;
            ST_DOT_ACC:
            begin
                acc_next = acc_sum;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = ST_DBL;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DOT_MUL;
                end
            end
            ST_DBL:
            begin
                s1 = sat32(trunc16(acc_reg));
                s2 = sat32(66'($signed(s1.v)) + 66'($signed(s1.v)));
                d_next       = s2.v;
                res_next.sat = res_reg.sat | s1.f | s2.f;
                state_next   = ST_W_MUL;
            end
            ST_W_MUL:
                state_next = ST_W_ACC;
            ST_W_ACC:
            begin
                // w = b*d + n, where the negated unit incident is -n
                s1 = sat32(trunc16(prod_reg));
                s2 = sat32(66'($signed(s1.v)) + 66'($signed(q_reg[idx_reg])));
                vec_next[idx_reg] = s2.v;
                res_next.sat      = res_reg.sat | s1.f | s2.f;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    pass_next  = 1'b1;
                    acc_next   = '0;
                    state_next = ST_SQ_MUL;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_W_MUL;
                end
            end
            ST_SC_MUL:
                state_next = ST_SC_ACC;
            ST_SC_ACC:
            begin
                s1 = sat32(trunc16(prod_reg));
                res_next.r[idx_reg] = s1.v;
                res_next.sat        = res_reg.sat | s1.f;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SC_MUL;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        pass_reg <= pass_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        vec_reg  <= vec_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        x_reg    <= x_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        len_reg  <= len_next;
        la_reg   <= la_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

endmodule

/* rtl/core/v3a_back.sv */
module v3a_back
    import v3a_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  item_t        head_item,
    input  logic         head_valid,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,
    output logic [0:0]   m_tuser
);

    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;
    logic               e1_valid_reg, e1_valid_next;
    logic [3:0]         e1_op_reg;
    logic signed [64:0] m0_reg [3];
    logic signed [63:0] m1_reg [3];
    logic signed [33:0] addv_reg [3];
    logic [2:0][31:0]   a_reg;

    logic signed [32:0] x0 [3];
    logic signed [31:0] y0 [3];
    logic signed [31:0] x1 [3];
    logic signed [31:0] y1 [3];
    logic signed [33:0] addv [3];
    logic signed [64:0] m0 [3];
    logic signed [63:0] m1 [3];
    res_t               s2;

    logic       out_free;
    logic       e1_adv;
    logic       e1_load;
    logic       slow_start;
    logic       slow_take;
    slow_stat_t slow_stat;
    res_t       slow_res;

    assign out_free   = !out_valid_reg || m_tready;
    assign e1_adv     = e1_valid_reg && out_free;
    assign e1_load    = head_valid && !head_item.slow && !slow_stat.busy &&
                        (!e1_valid_reg || out_free);
    assign slow_start = head_valid && head_item.slow && !slow_stat.busy && !e1_valid_reg;
    assign slow_take  = slow_stat.done && out_free;
    assign pop        = e1_load || slow_start;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.so, out_reg.r};
    assign m_tuser  = out_reg.sat;

    v3a_slow u_slow (
        .clk   (clk),
        .rst_n (rst_n),
        .start (slow_start),
        .item  (head_item),
        .take  (slow_take),
        .stat  (slow_stat),
        .res   (slow_res)
    );

    // lane operand select, lane i of cross is a[i+1]*b[i+2] - a[i+2]*b[i+1]
    always_comb
    begin
        logic signed [31:0] ai, bi, an, ap, bn, bp, sc;
        int nx, pv;
        sc = $signed(head_item.sc);
        for (int i = 0; i < 3; i++)
        begin
            nx = (i == 2) ? 0 : i + 1;
            pv = (i == 0) ? 2 : i - 1;
            ai = $signed(head_item.a[i]);
            bi = $signed(head_item.b[i]);
            an = $signed(head_item.a[nx]);
            ap = $signed(head_item.a[pv]);
            bn = $signed(head_item.b[nx]);
            bp = $signed(head_item.b[pv]);
            x0[i]   = '0;
            y0[i]   = '0;
            x1[i]   = '0;
            y1[i]   = '0;
            addv[i] = '0;
            case (head_item.op) inside
                OP_ADD:    addv[i] = 34'(ai) + 34'(bi);
                OP_SUB:    addv[i] = 34'(ai) - 34'(bi);
                OP_NEGATE: addv[i] = -34'(ai);
                OP_ABS:    addv[i] = ai[31] ? -34'(ai) : 34'(ai);
                OP_MUL, OP_DOT:
                begin
                    x0[i] = 33'(ai);
                    y0[i] = bi;
                end
                OP_SCALE:
                begin
                    x0[i] = 33'(ai);
                    y0[i] = sc;
                end
                OP_LERP:
                begin
                    x0[i] = 33'(bi) - 33'(ai);
                    y0[i] = sc;
                end
                OP_CROSS:
                begin
                    x0[i] = 33'(an);
                    y0[i] = bp;
                    x1[i] = ap;
                    y1[i] = bn;
                end
                default:
                begin
                    x0[i] = '0;
                end
            endcase
            m0[i] = 65'(x0[i]) * 65'(y0[i]);
            m1[i] = 64'(x1[i]) * 64'(y1[i]);
        end
    end

    // second stage: truncate, sum and clamp
    always_comb
    begin
        sat_t st;
        logic signed [65:0] t;
        s2 = '0;
        for (int i = 0; i < 3; i++)
        begin
            st = '0;
            t  = '0;
            case (e1_op_reg) inside
                OP_ADD, OP_SUB, OP_NEGATE, OP_ABS:
                    st = sat32(66'(addv_reg[i]));
                OP_MUL, OP_SCALE:
                    st = sat32(trunc16(66'(m0_reg[i])));
                OP_LERP:
                begin
                    t  = trunc16(66'(m0_reg[i]));
                    st = sat32(t + 66'($signed(a_reg[i])));
                end
                OP_CROSS:
                    st = sat32(trunc16(66'(m0_reg[i]) - 66'(m1_reg[i])));
                default:
                    st = '0;
            endcase
            s2.r[i] = st.v;
            s2.sat  = s2.sat | st.f;
        end
        if (e1_op_reg == OP_DOT)
        begin
            st = sat32(trunc16(66'(m0_reg[0]) + 66'(m0_reg[1]) + 66'(m0_reg[2])));
            s2.so  = st.v;
            s2.sat = st.f;
        end
    end

    always_comb
    begin
        e1_valid_next = e1_valid_reg;
        if (e1_load)
            e1_valid_next = 1'b1;
        else if (e1_adv)
            e1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (e1_adv)
        begin
            out_valid_next = 1'b1;
            out_next       = s2;
        end
        else if (slow_take)
        begin
            out_valid_next = 1'b1;
            out_next       = slow_res;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            e1_valid_reg  <= e1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (e1_load)
        begin
            e1_op_reg <= head_item.op;
            a_reg     <= head_item.a;
            for (int i = 0; i < 3; i++)
            begin
                m0_reg[i]   <= m0[i];
                m1_reg[i]   <= m1[i];
                addv_reg[i] <= addv[i];
            end
        end
    end

endmodule

/* rtl/core/vec3_fixed_point_alu.sv */
// channel   dir  tdata (low bit up)                          tuser
// s_axis    in   a_x a_y a_z b_x b_y b_z scalar_in (224)     action (4)
// m_axis    out  r_x r_y r_z scalar_out (128)                saturated (1)
//
// add, sub, mul, scale, negate, abs, cross, dot and lerp stream at one
// transaction per cycle through a two-stage multiply and clamp pipe while
// no iterative action runs and the output is not held. length, normalize and
// reflect use the bit-serial square root and the one-bit-per-cycle divider.
// reset clears only control state; the input queue stalls on its own while
// the back end runs an iterative action or the output is held.
module vec3_fixed_point_alu
    import v3a_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
    input  logic [3:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // r_x, r_y, r_z, scalar_out
    output logic [0:0]   m_tuser    // saturated
);

    item_t push_item;
    logic  push_valid;
    logic  push_ready;
    item_t head_item;
    logic  head_valid;
    logic  pop;

    v3a_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    v3a_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head_item  (head_item),
        .head_valid (head_valid),
        .pop        (pop)
    );

    v3a_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import v3a_pkg::*;

    typedef struct {
        logic [3:0]         act;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic signed [31:0] s;
    } vec_op_t;

    typedef struct {
        logic [31:0] r [3];
        logic [31:0] so;
        logic        sat;
    } vec_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;

    vec_op_t  pending_ops [$];
    vec_res_t expected_res [$];
    int       mismatches;
    int       results_seen;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_off_cycles;
    bit       stim_done;

    vec3_fixed_point_alu uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                   inout logic f);
        if (v > 128'sd2147483647)
        begin
            f = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sd2147483648)
        begin
            f = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // signed division truncating toward zero
    function automatic logic signed [127:0] div_tz(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = un / ud;
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        lo = 0;
        hi = 128'h1_0000_0000_0000_0000;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= x)
                lo = mid;
            else
                hi = mid;
        end
        return lo[63:0];
    endfunction

    function automatic logic [63:0] vec_len(input logic signed [31:0] v [3]);
        logic [127:0] acc;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += 128'(v[i]) * 128'(v[i]);
        return floor_sqrt(acc);
    endfunction

    function automatic void unit_vec(input logic signed [31:0] v [3],
                                     output logic signed [31:0] o [3]);
        logic [63:0] l;
        logic signed [127:0] q;
        l = vec_len(v);
        for (int i = 0; i < 3; i++)
        begin
            q = (l == 0) ? 0 : div_tz(128'(v[i]) * 65536, $signed({64'd0, l}));
            o[i] = q[31:0];
        end
    endfunction

    function automatic logic signed [127:0] prod(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
        return 128'(x) * 128'(y);
    endfunction

    function automatic vec_res_t alu_predict(input vec_op_t t);
        vec_res_t o;
        logic f;
        logic signed [31:0] u [3];
        logic signed [31:0] w [3];
        logic signed [31:0] d;
        logic signed [31:0] m;
        logic [63:0] l;
        f = 1'b0;
        o.so = 0;
        for (int i = 0; i < 3; i++)
            o.r[i] = 0;
        case (t.act)
            OP_ADD:
                for (int i = 0; i < 3; i++)
                    o.r[i] = clamp32(128'(t.a[i]) + 128'(t.b[i]), f);
            OP_SUB:
                for (int i = 0; i < 3; i++)
                    o.r[i] = clamp32(128'(t.a[i]) - 128'(t.b[i]), f);
            OP_MUL:
                for (int i = 0; i < 3; i++)
                    o.r[i] = clamp32(div_tz(prod(t.a[i], t.b[i]), 65536), f);
            OP_SCALE:
                for (int i = 0; i < 3; i++)
                    o.r[i] = clamp32(div_tz(prod(t.a[i], t.s), 65536), f);
            OP_NEGATE:
                for (int i = 0; i < 3; i++)
                    o.r[i] = clamp32(-128'(t.a[i]), f);
            OP_ABS:
                for (int i = 0; i < 3; i++)
                    o.r[i] = clamp32(t.a[i] < 0 ? -128'(t.a[i]) : 128'(t.a[i]), f);
            OP_CROSS:
            begin
                o.r[0] = clamp32(div_tz(prod(t.a[1], t.b[2]) - prod(t.a[2], t.b[1]),
                                        65536), f);
                o.r[1] = clamp32(div_tz(prod(t.a[2], t.b[0]) - prod(t.a[0], t.b[2]),
                                        65536), f);
                o.r[2] = clamp32(div_tz(prod(t.a[0], t.b[1]) - prod(t.a[1], t.b[0]),
                                        65536), f);
            end
            OP_DOT:
                o.so = clamp32(div_tz(prod(t.a[0], t.b[0]) + prod(t.a[1], t.b[1])
                                      + prod(t.a[2], t.b[2]), 65536), f);
            OP_LERP:
                for (int i = 0; i < 3; i++)
                    o.r[i] = clamp32(div_tz((128'(t.b[i]) - 128'(t.a[i])) * 128'(t.s),
                                            65536) + 128'(t.a[i]), f);
            OP_LENGTH:
                o.so = clamp32($signed({64'd0, vec_len(t.a)}), f);
            OP_NORMALIZE:
            begin
                unit_vec(t.a, u);
                for (int i = 0; i < 3; i++)
                    o.r[i] = u[i];
            end
            OP_REFLECT:
            begin
                l = vec_len(t.a);
                unit_vec(t.a, u);
                for (int i = 0; i < 3; i++)
                    u[i] = -u[i];
                d = clamp32(div_tz(prod(u[0], t.b[0]) + prod(u[1], t.b[1])
                                   + prod(u[2], t.b[2]), 65536), f);
                d = clamp32(128'(d) + 128'(d), f);
                for (int i = 0; i < 3; i++)
                begin
                    m = clamp32(div_tz(prod(t.b[i], d), 65536), f);
                    w[i] = clamp32(128'(m) - 128'(u[i]), f);
                end
                unit_vec(w, u);
                for (int i = 0; i < 3; i++)
                    o.r[i] = clamp32(div_tz(128'(u[i]) * $signed({64'd0, l}), 65536), f);
            end
            default: ;
        endcase
        o.sat = f;
        return o;
    endfunction

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 8)) - 4;
            2: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
            3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h2000000)) - 32'sh1000000;
        endcase
    endfunction

    task automatic push_op(input logic [3:0] act, input logic signed [31:0] av,
                           input logic signed [31:0] bv, input logic signed [31:0] sv);
        vec_op_t t;
        t.act = act;
        for (int i = 0; i < 3; i++)
        begin
            t.a[i] = av;
            t.b[i] = bv;
        end
        t.s = sv;
        pending_ops.push_back(t);
    endtask

    task automatic push_random(input int n);
        vec_op_t t;
        for (int k = 0; k < n; k++)
        begin
            // iterative actions are slow, keep them a minority
            t.act = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 8))
                                                : 4'($urandom_range(9, 15));
            for (int i = 0; i < 3; i++)
            begin
                t.a[i] = rand_val();
                t.b[i] = rand_val();
            end
            t.s = rand_val();
            pending_ops.push_back(t);
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_tvalid || expected_res.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    // driver, the head of the queue is the item on the bus while s_tvalid is high
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                expected_res.push_back(alu_predict(pending_ops.pop_front()));
            if (pending_ops.size() != 0 && $urandom_range(1, 100) > send_idle_pct)
            begin
                vec_op_t t;
                t = pending_ops[0];
                s_tvalid <= 1'b1;
                s_tuser  <= t.act;
                s_tdata  <= {t.s, t.b[2], t.b[1], t.b[0], t.a[2], t.a[1], t.a[0]};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver stall, with a long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(1, 100) > recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_res.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected transaction: %h sat %b", m_tdata, m_tuser);
            end
            else
            begin
                vec_res_t e;
                e = expected_res.pop_front();
                if (m_tdata !== {e.so, e.r[2], e.r[1], e.r[0]} || m_tuser[0] !== e.sat)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp %h sat %b, got %h sat %b",
                                 {e.so, e.r[2], e.r[1], e.r[0]}, e.sat, m_tdata, m_tuser);
                end
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic signed [31:0] extremes [6];
        extremes = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh10000, -32'sh10000, 1};
        rst_n = 1'b0;
        mismatches = 0;
        results_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        stim_done = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every action at extremes, zero-length normalize and reflect,
        // undefined codes
        for (int k = 0; k < 16; k++)
            push_op(4'(k), extremes[k % 6], extremes[(k + 1) % 6], extremes[(k + 3) % 6]);
        push_op(OP_NORMALIZE, 0, 0, 0);
        push_op(OP_REFLECT, 0, 32'sh10000, 0);
        push_op(OP_REFLECT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
        push_op(OP_LENGTH, 32'sh8000_0000, 0, 0);
        push_op(OP_LERP, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_op(OP_DOT, 32'sh8000_0000, 32'sh8000_0000, 0);
        push_op(OP_CROSS, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        push_op(OP_NORMALIZE, 1, 0, 0);
        wait_drained();

        push_random(350);
        wait_drained();
        send_idle_pct = 78;
        push_random(350);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 78;
        push_random(350);
        wait_drained();
        send_idle_pct = 13;
        recv_stall_pct = 13;
        // long receiver hold-off while the sender keeps offering
        hold_off_cycles = 400;
        push_random(380);
        wait_drained();

        $display("%0d results checked over all actions incl. undefined codes,", results_seen);
        $display("with sender gaps, receiver stalls and a long output hold-off");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* vec3_fixed_point_alu.f */
rtl/core/v3a_pkg.sv
rtl/core/v3a_front.sv
rtl/core/v3a_fifo.sv
rtl/core/v3a_slow.sv
rtl/core/v3a_back.sv
rtl/core/vec3_fixed_point_alu.sv
dv/testbench.sv
